FILE: rtl/xml_stream_tokenizer_unit_defines.svh
// assertion macros used by the tokenizer queue
`ifndef XML_STREAM_TOKENIZER_UNIT_DEFINES_SVH
`define XML_STREAM_TOKENIZER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define XST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("xst check failed");
`define XST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xst check failed");
`else
`define XST_ASSERT(lbl, prop)
`define XST_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/xst_pkg.sv
// types, constants and lexer step functions for the xml stream tokenizer
package xst_pkg;

  localparam int ENT_DEPTH = 6;
  localparam int ENT_CNT_W = $clog2(ENT_DEPTH + 1);
  localparam int ENT_IDX_W = $clog2(ENT_DEPTH);
  localparam int MAX_RES   = 8;
  localparam int Q_DEPTH   = 4;

  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_LF    = 8'h0a;
  localparam logic [7:0] C_SP    = 8'h20;
  localparam logic [7:0] C_AMP   = 8'h26;
  localparam logic [7:0] C_SEMI  = 8'h3b;
  localparam logic [7:0] C_LT    = 8'h3c;
  localparam logic [7:0] C_GT    = 8'h3e;
  localparam logic [7:0] C_DASH  = 8'h2d;
  localparam logic [7:0] C_RB    = 8'h5d;
  localparam logic [7:0] C_LB    = 8'h5b;
  localparam logic [7:0] C_QM    = 8'h3f;
  localparam logic [7:0] C_EQ    = 8'h3d;
  localparam logic [7:0] C_BANG  = 8'h21;
  localparam logic [7:0] C_SLASH = 8'h2f;
  localparam logic [7:0] C_QUOT  = 8'h22;
  localparam logic [7:0] C_APOS  = 8'h27;
  localparam logic [7:0] C_US    = 8'h5f;
  localparam logic [7:0] C_COLON = 8'h3a;
  localparam logic [7:0] C_DOT   = 8'h2e;

  typedef enum logic [4:0] {
    M_IDLE = 5'd0, M_LT = 5'd1, M_BANG = 5'd2, M_BDASH = 5'd3,
    M_CD0 = 5'd4, M_CD1 = 5'd5, M_CD2 = 5'd6, M_CD3 = 5'd7, M_CD4 = 5'd8, M_CD5 = 5'd9,
    M_SLASH = 5'd10, M_QMARK = 5'd11, M_RB1 = 5'd12, M_RB2 = 5'd13,
    M_DASH1 = 5'd14, M_DASH2 = 5'd15, M_NAME = 5'd16, M_QUOTE = 5'd17,
    M_SKIPSP = 5'd18, M_SKIPLT = 5'd19, M_TEXT = 5'd20,
    M_CT0 = 5'd21, M_CT1 = 5'd22, M_CT2 = 5'd23,
    M_DT0 = 5'd24, M_DT1 = 5'd25, M_DT2 = 5'd26
  } xst_mode_e;

  typedef enum logic [3:0] {
    T_EOF = 4'd0, T_OPEN = 4'd1, T_CLOSE = 4'd2, T_OPEN_CLOSE = 4'd3,
    T_FINAL_CLOSE = 4'd4, T_PROLOG_OPEN = 4'd5, T_PROLOG_CLOSE = 4'd6,
    T_COMMENT_OPEN = 4'd7, T_COMMENT_CLOSE = 4'd8, T_CDATA_BEGIN = 4'd9,
    T_CDATA_END = 4'd10, T_EQUAL = 4'd11, T_NAME = 4'd12, T_VALUE = 4'd13,
    T_TEXT = 4'd14, T_UNDEF = 4'd15
  } xst_tok_e;

  typedef enum logic {EV_BYTE = 1'b0, EV_TOKEN = 1'b1} xst_ev_e;

  typedef struct packed {
    xst_ev_e    kind;
    xst_tok_e   typ;
    logic [7:0] data;
  } xst_res_t;

  typedef struct packed {
    xst_res_t [MAX_RES-1:0] items;
    logic [3:0]             cnt;
  } xst_bundle_t;

  localparam int BUNDLE_W = $bits(xst_bundle_t);

  typedef struct packed {
    xst_mode_e                       mode;
    logic                            start;
    xst_tok_e                        prev;
    logic                            qk;
    logic [ENT_CNT_W-1:0]            ecnt;
    logic [ENT_DEPTH-1:0][7:0]       ebuf;
    xst_bundle_t                     acc;
  } xst_work_t;

  typedef struct packed {
    xst_work_t w;
    logic      again;
  } xst_proc_t;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_name_ch(logic [7:0] b);
    return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == C_US || b == C_DASH ||
           b == C_DOT || b == C_COLON;
  endfunction

  function automatic logic [7:0] cd_ch(xst_mode_e m);
    case (m)
      M_CD0:   return 8'h43;
      M_CD1:   return 8'h44;
      M_CD2:   return 8'h41;
      M_CD3:   return 8'h54;
      M_CD4:   return 8'h41;
      M_CD5:   return C_LB;
      default: return 8'h00;
    endcase
  endfunction

  // entity names after the ampersand: lt; gt; amp; apos; quot;
  function automatic logic [7:0] ent_ch(logic [2:0] k, logic [2:0] i);
    logic [39:0] s;
    case (k)
      3'd0:    s = {8'h00, 8'h00, C_SEMI, 8'h74, 8'h6c};
      3'd1:    s = {8'h00, 8'h00, C_SEMI, 8'h74, 8'h67};
      3'd2:    s = {8'h00, C_SEMI, 8'h70, 8'h6d, 8'h61};
      3'd3:    s = {C_SEMI, 8'h73, 8'h6f, 8'h70, 8'h61};
      3'd4:    s = {C_SEMI, 8'h74, 8'h6f, 8'h75, 8'h71};
      default: s = '0;
    endcase
    case (i)
      3'd0:    return s[7:0];
      3'd1:    return s[15:8];
      3'd2:    return s[23:16];
      3'd3:    return s[31:24];
      3'd4:    return s[39:32];
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] ent_len(logic [2:0] k);
    case (k)
      3'd0, 3'd1: return 3'd3;
      3'd2:       return 3'd4;
      default:    return 3'd5;
    endcase
  endfunction

  function automatic logic [7:0] ent_val(logic [2:0] k);
    case (k)
      3'd0:    return C_LT;
      3'd1:    return C_GT;
      3'd2:    return C_AMP;
      3'd3:    return C_APOS;
      default: return C_QUOT;
    endcase
  endfunction

  function automatic xst_work_t w_put(xst_work_t w, xst_res_t r);
    if (w.acc.cnt < 4'(MAX_RES)) begin
      w.acc.items[w.acc.cnt[2:0]] = r;
      w.acc.cnt = w.acc.cnt + 4'd1;
    end
    return w;
  endfunction

  function automatic xst_work_t w_emit(xst_work_t w, logic [7:0] b);
    xst_res_t r;
    r = '{kind: EV_BYTE, typ: T_EOF, data: b};
    return w_put(w, r);
  endfunction

  function automatic xst_work_t w_fin(xst_work_t w, xst_tok_e t);
    xst_res_t r;
    r = '{kind: EV_TOKEN, typ: t, data: 8'h00};
    w = w_put(w, r);
    w.prev = t;
    w.start = 1'b0;
    return w;
  endfunction

  function automatic xst_work_t w_flush(xst_work_t w);
    for (int i = 0; i < ENT_DEPTH; i++) begin
      if (i < int'(w.ecnt)) w = w_emit(w, w.ebuf[i]);
    end
    w.ecnt = '0;
    return w;
  endfunction

  // 0 no match, 1 prefix, 2+k entity k complete
  function automatic logic [2:0] ent_match(xst_work_t w, logic [7:0] b);
    logic [2:0] r;
    logic [2:0] n;
    logic       ok;
    r = 3'd0;
    n = 3'(w.ecnt - ENT_CNT_W'(1));
    if (w.ecnt == '0 || int'(w.ecnt) >= ENT_DEPTH) return 3'd0;
    for (int k = 0; k < 5; k++) begin
      ok = (n < ent_len(3'(k)));
      for (int i = 0; i < 5; i++) begin
        if (i < int'(n) && w.ebuf[i+1] != ent_ch(3'(k), 3'(i))) ok = 1'b0;
      end
      if (ok && ent_ch(3'(k), n) == b) begin
        if (int'(n) + 1 == int'(ent_len(3'(k)))) return 3'(k + 2);
        r = 3'd1;
      end
    end
    return r;
  endfunction

  function automatic xst_work_t w_feed(xst_work_t w, logic [7:0] b);
    logic [2:0] m;
    logic       done;
    done = 1'b0;
    m = ent_match(w, b);
    if (w.ecnt != '0) begin
      if (m >= 3'd2) begin
        w = w_emit(w, ent_val(m - 3'd2));
        w.ecnt = '0;
        done = 1'b1;
      end else if (m == 3'd1) begin
        w.ebuf[w.ecnt[ENT_IDX_W-1:0]] = b;
        w.ecnt = w.ecnt + ENT_CNT_W'(1);
        done = 1'b1;
      end else if (w.ecnt == ENT_CNT_W'(1)) begin
        // lone ampersand goes out, byte is looked at again below
        w = w_emit(w, C_AMP);
        w.ecnt = '0;
      end else begin
        w = w_flush(w);
        w = w_emit(w, b);
        done = 1'b1;
      end
    end
    if (!done) begin
      if (b == C_AMP) begin
        w.ebuf[0] = C_AMP;
        w.ecnt = ENT_CNT_W'(1);
      end else begin
        w = w_emit(w, b);
      end
    end
    return w;
  endfunction

  function automatic xst_work_t w_bad(xst_work_t w, logic [7:0] b);
    w = w_emit(w, b);
    w = w_fin(w, T_UNDEF);
    w.mode = M_SKIPSP;
    return w;
  endfunction

  function automatic xst_proc_t w_proc(xst_work_t w, logic [7:0] b);
    xst_proc_t  r;
    logic       ag;
    logic [7:0] c;
    ag = 1'b0;
    c = (w.mode == M_CT0 || w.mode == M_CT1 || w.mode == M_CT2) ? C_DASH : C_RB;
    case (w.mode)
      M_IDLE: begin
        if (b != C_TAB && b != C_LF && b != C_SP) begin
          if (!w.start && w.prev == T_COMMENT_OPEN) begin
            w.mode = M_CT0;
            ag = 1'b1;
          end else if (!w.start && w.prev == T_CDATA_BEGIN) begin
            w.mode = M_DT0;
            ag = 1'b1;
          end else if (!w.start && w.prev == T_CLOSE && b != C_LT) begin
            w.ecnt = '0;
            w.mode = M_TEXT;
            ag = 1'b1;
          end else if (is_alpha(b) || b == C_US || b == C_COLON) begin
            w = w_emit(w, b);
            w.mode = M_NAME;
          end else begin
            case (b)
              C_LT: begin
                w = w_emit(w, b);
                w.mode = M_LT;
              end
              C_SLASH: begin
                w = w_emit(w, b);
                w.mode = M_SLASH;
              end
              C_QM: begin
                w = w_emit(w, b);
                w.mode = M_QMARK;
              end
              C_GT: begin
                w = w_emit(w, b);
                w = w_fin(w, T_CLOSE);
              end
              C_RB: begin
                w = w_emit(w, b);
                w.mode = M_RB1;
              end
              C_EQ: begin
                w = w_emit(w, b);
                w = w_fin(w, T_EQUAL);
              end
              C_DASH: begin
                w = w_emit(w, b);
                w.mode = M_DASH1;
              end
              C_QUOT: begin
                w.qk = 1'b0;
                w.ecnt = '0;
                w.mode = M_QUOTE;
              end
              C_APOS: begin
                w.qk = 1'b1;
                w.ecnt = '0;
                w.mode = M_QUOTE;
              end
              default: w.mode = M_SKIPLT;
            endcase
          end
        end
      end
      M_CD0, M_CD1, M_CD2, M_CD3, M_CD4, M_CD5: begin
        if (b != cd_ch(w.mode)) begin
          w = w_bad(w, b);
        end else begin
          w = w_emit(w, b);
          if (w.mode == M_CD5) begin
            w = w_fin(w, T_CDATA_BEGIN);
            w.mode = M_IDLE;
          end else begin
            w.mode = xst_mode_e'(w.mode + 5'd1);
          end
        end
      end
      M_LT: begin
        if (b == C_SLASH || b == C_QM) begin
          w = w_emit(w, b);
          w = w_fin(w, (b == C_SLASH) ? T_OPEN_CLOSE : T_PROLOG_OPEN);
          w.mode = M_IDLE;
        end else if (b == C_BANG) begin
          w = w_emit(w, b);
          w.mode = M_BANG;
        end else begin
          w = w_fin(w, T_OPEN);
          w.mode = M_IDLE;
          ag = 1'b1;
        end
      end
      M_BANG: begin
        if (b == C_DASH) begin
          w = w_emit(w, b);
          w.mode = M_BDASH;
        end else if (b == C_LB) begin
          w = w_emit(w, b);
          w.mode = M_CD0;
        end else begin
          w = w_bad(w, b);
        end
      end
      M_BDASH: begin
        if (b == C_DASH) begin
          w = w_emit(w, b);
          w = w_fin(w, T_COMMENT_OPEN);
          w.mode = M_IDLE;
        end else begin
          w = w_bad(w, b);
        end
      end
      M_SLASH, M_QMARK: begin
        if (b == C_GT) begin
          w = w_emit(w, b);
          w = w_fin(w, (w.mode == M_SLASH) ? T_FINAL_CLOSE : T_PROLOG_CLOSE);
          w.mode = M_IDLE;
        end else begin
          w = w_fin(w, T_UNDEF);
          w.mode = M_SKIPSP;
          ag = 1'b1;
        end
      end
      M_RB1, M_DASH1: begin
        if (b == ((w.mode == M_RB1) ? C_RB : C_DASH)) begin
          w = w_emit(w, b);
          w.mode = xst_mode_e'(w.mode + 5'd1);
        end else begin
          w = w_bad(w, b);
        end
      end
      M_RB2, M_DASH2: begin
        if (b == C_GT) begin
          w = w_emit(w, b);
          w = w_fin(w, (w.mode == M_RB2) ? T_CDATA_END : T_COMMENT_CLOSE);
          w.mode = M_IDLE;
        end else begin
          w = w_bad(w, b);
        end
      end
      M_NAME: begin
        if (is_name_ch(b)) begin
          w = w_emit(w, b);
        end else begin
          w = w_fin(w, T_NAME);
          w.mode = M_IDLE;
          ag = 1'b1;
        end
      end
      M_QUOTE: begin
        if (b == (w.qk ? C_APOS : C_QUOT)) begin
          w = w_flush(w);
          w = w_fin(w, T_VALUE);
          w.mode = M_IDLE;
        end else begin
          w = w_feed(w, b);
        end
      end
      M_SKIPSP: begin
        if (b == C_SP) w.mode = M_IDLE;
      end
      M_SKIPLT: begin
        if (b == C_LT) begin
          w.mode = M_IDLE;
          ag = 1'b1;
        end
      end
      M_TEXT: begin
        if (b == C_LT) begin
          w = w_flush(w);
          w = w_fin(w, T_TEXT);
          w.mode = M_IDLE;
          ag = 1'b1;
        end else begin
          w = w_feed(w, b);
        end
      end
      M_CT0, M_DT0: begin
        if (b == c) w.mode = xst_mode_e'(w.mode + 5'd1);
        else w = w_emit(w, b);
      end
      M_CT1, M_DT1: begin
        if (b == c) begin
          w.mode = xst_mode_e'(w.mode + 5'd1);
        end else begin
          w = w_emit(w, c);
          w.mode = xst_mode_e'(w.mode - 5'd1);
          ag = 1'b1;
        end
      end
      M_CT2, M_DT2: begin
        if (b == C_GT) begin
          w = w_fin(w, T_TEXT);
          w = w_emit(w, c);
          w = w_emit(w, c);
          w = w_emit(w, b);
          w = w_fin(w, (w.mode == M_CT2) ? T_COMMENT_CLOSE : T_CDATA_END);
          w.mode = M_IDLE;
        end else begin
          w = w_emit(w, c);
          w = w_emit(w, c);
          w.mode = xst_mode_e'(w.mode - 5'd2);
          ag = 1'b1;
        end
      end
      default: begin
        w.mode = M_IDLE;
        ag = 1'b1;
      end
    endcase
    r.w = w;
    r.again = ag;
    return r;
  endfunction

  function automatic xst_work_t w_eod(xst_work_t w);
    logic [7:0] c;
    c = (w.mode == M_CT0 || w.mode == M_CT1 || w.mode == M_CT2) ? C_DASH : C_RB;
    case (w.mode)
      M_LT: w = w_fin(w, T_OPEN);
      M_BANG, M_BDASH, M_CD0, M_CD1, M_CD2, M_CD3, M_CD4, M_CD5,
      M_SLASH, M_QMARK, M_RB1, M_RB2, M_DASH1, M_DASH2: w = w_fin(w, T_UNDEF);
      M_NAME: w = w_fin(w, T_NAME);
      M_QUOTE: begin
        w = w_flush(w);
        w = w_fin(w, T_VALUE);
      end
      M_TEXT: begin
        w = w_flush(w);
        w = w_fin(w, T_TEXT);
      end
      M_CT0, M_DT0: w = w_fin(w, T_TEXT);
      M_CT1, M_DT1: begin
        w = w_emit(w, c);
        w = w_fin(w, T_TEXT);
      end
      M_CT2, M_DT2: begin
        w = w_emit(w, c);
        w = w_emit(w, c);
        w = w_fin(w, T_TEXT);
      end
      default: ;
    endcase
    w.mode = M_IDLE;
    w = w_fin(w, T_EOF);
    return w;
  endfunction

endpackage

FILE: rtl/xml_stream_tokenizer_unit.sv
// Streaming XML tokenizer. One document byte (or an end-of-input mark in tuser)
// is taken per cycle whenever the four-entry result queue has room; the front
// end lexes the byte in that cycle and stores its results (up to eight) as
// one queue entry, or none for a byte with no results. The back end sends them
// one per cycle while the output is ready, so input keeps flowing until the
// queue fills; the output port, one result per cycle, sets the sustained
// rate. tlast marks the final result of each input item.
module xml_stream_tokenizer_unit #(
  parameter int LINE_BITS = 24
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [7:0]                                s_axis_tdata,  // data_byte
  input  logic                                      s_axis_tuser,  // end_of_input
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // token_type[3:0], data_byte_out[11:4], line_number above, zero pad
  output logic [((12+LINE_BITS+7)/8)*8-1:0]         m_axis_tdata,
  output logic                                      m_axis_tuser,  // event_kind
  output logic                                      m_axis_tlast
);
  import xst_pkg::*;

  localparam int OUT_W = ((12 + LINE_BITS + 7) / 8) * 8;
  localparam int ENT_W = LINE_BITS + BUNDLE_W;

  logic             push, pop, full, empty;
  logic [ENT_W-1:0] push_data, head;

  xst_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eoi_i    (s_axis_tuser),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  xst_queue #(.WIDTH(ENT_W)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  xst_back #(.LINE_BITS(LINE_BITS), .OUT_W(OUT_W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: rtl/xst_front.sv
// front end: takes one byte item per cycle while the queue is not full and builds its bundle of results
module xst_front #(
  parameter int LINE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           in_byte_i,
  input  logic                                 in_eoi_i,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output logic [LINE_BITS+xst_pkg::BUNDLE_W-1:0] push_data_o
);
  import xst_pkg::*;

  xst_mode_e                 mode_q;
  logic                      start_q;
  xst_tok_e                  prev_q;
  logic                      qk_q;
  logic [ENT_CNT_W-1:0]      ecnt_q;
  logic [ENT_DEPTH-1:0][7:0] ebuf_q;
  logic [LINE_BITS-1:0]      line_q, line_d;
  xst_work_t                 w;
  xst_proc_t                 pr;
  logic                      go;
  logic                      accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // up to four passes: a byte can end one token and be rescanned as the next
  always_comb begin
    w = '{mode: mode_q, start: start_q, prev: prev_q, qk: qk_q, ecnt: ecnt_q,
          ebuf: ebuf_q, acc: '0};
    pr = '0;
    go = 1'b1;
    if (in_eoi_i) begin
      w = w_eod(w);
    end else begin
      for (int p = 0; p < 4; p++) begin
        if (go) begin
          pr = w_proc(w, in_byte_i);
          w = pr.w;
          go = pr.again;
        end
      end
    end
  end

  always_comb begin
    line_d = line_q;
    if (!in_eoi_i && in_byte_i == C_LF && line_q != {LINE_BITS{1'b1}}) begin
      line_d = line_q + LINE_BITS'(1);
    end
  end

  assign push_o      = accept && (w.acc.cnt != 4'd0);
  assign push_data_o = {line_q, w.acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= 1'b1;
      prev_q  <= T_EOF;
      qk_q    <= 1'b0;
      ecnt_q  <= '0;
      line_q  <= LINE_BITS'(1);
    end else if (accept) begin
      mode_q  <= w.mode;
      start_q <= w.start;
      prev_q  <= w.prev;
      qk_q    <= w.qk;
      ecnt_q  <= w.ecnt;
      line_q  <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) ebuf_q <= w.ebuf;
  end

endmodule

FILE: rtl/xst_queue.sv
// short fifo of result bundles between the front and back ends
`include "xml_stream_tokenizer_unit_defines.svh"
module xst_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             full_o,
  output logic             empty_o
);
  import xst_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [Q_DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PTR_W-1:0]              wr_q, rd_q;
  logic [CNT_W-1:0]              cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CNT_W'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= wr_q + PTR_W'(1);
      if (pop_i) rd_q <= rd_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  `XST_ASSERT(a_no_overflow, !(push_i && full_o))
  `XST_ASSERT(a_no_underflow, !(pop_i && empty_o))
  `XST_ASSERT_NEXT(a_push_grows, push_i && !pop_i, cnt_q == CNT_W'($past(cnt_q) + 1'b1))
  `XST_ASSERT_NEXT(a_pop_shrinks, pop_i && !push_i, cnt_q == CNT_W'($past(cnt_q) - 1'b1))

endmodule

FILE: rtl/xst_back.sv
// back end: sends the items of the head bundle out one per cycle while the output is ready
module xst_back #(
  parameter int LINE_BITS = 24,
  parameter int OUT_W     = 40
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [LINE_BITS+xst_pkg::BUNDLE_W-1:0] head_i,
  input  logic                                   empty_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [OUT_W-1:0]                       out_data_o,
  output logic                                   out_kind_o,
  output logic                                   out_last_o
);
  import xst_pkg::*;

  xst_bundle_t          hb;
  logic [LINE_BITS-1:0] line;
  xst_res_t             r;
  logic [2:0]           idx_q, idx_d;
  logic                 take;

  assign hb   = xst_bundle_t'(head_i[BUNDLE_W-1:0]);
  assign line = head_i[LINE_BITS+BUNDLE_W-1:BUNDLE_W];
  assign r    = hb.items[idx_q];

  assign out_valid_o = !empty_i;
  assign out_last_o  = ({1'b0, idx_q} + 4'd1 == hb.cnt);
  assign out_kind_o  = r.kind;
  assign out_data_o  = OUT_W'({line, r.data, r.typ});
  assign take        = out_valid_o && out_ready_i;
  assign pop_o       = take && out_last_o;

  always_comb begin
    idx_d = idx_q;
    if (take) idx_d = out_last_o ? 3'd0 : idx_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 3'd0;
    else idx_q <= idx_d;
  end

endmodule
